// File: rtl/pbtfs_pkg.sv
// ============================================================================
// pbtfs_pkg: shared types and codes for the protobuf type field scanner
// Holds the request, result and configuration structs and the status codes.
// ============================================================================
`default_nettype none

package pbtfs_pkg;

    // Status codes of one result
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_NOT_MEDIA = 3'd1;
    localparam logic [2:0] ST_MEDIA     = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_TARGET_FIELD = 2'd0;
    localparam logic [1:0] REG_MEDIA_TYPE_A = 2'd1;
    localparam logic [1:0] REG_MEDIA_TYPE_B = 2'd2;

    // Reset values of the configuration registers
    localparam logic [31:0] TARGET_FIELD_RST = 32'd10;
    localparam logic [31:0] MEDIA_TYPE_A_RST = 32'd30;
    localparam logic [31:0] MEDIA_TYPE_B_RST = 32'd40;

    // One input request: a message byte and its end flag
    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } item_t;

    // One result
    typedef struct packed {
        logic [2:0] status;
        logic       is_media;
    } result_t;

    // Configuration seen by the scan core
    typedef struct packed {
        logic [31:0] target_field;
        logic [31:0] media_type_a;
        logic [31:0] media_type_b;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/pbtfs_core.sv
// ============================================================================
// pbtfs_core: per-byte wire format scan state
// Decodes tag, value and length varints, counts down skipped payloads and
// settles the verdict; updates all state once per byte, when step_en is high.
// ============================================================================
`default_nettype none

module pbtfs_core #(
    parameter int MAX_VARINT_BITS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire pbtfs_pkg::item_t  item,
    input  wire pbtfs_pkg::cfg_t   cfg,
    output pbtfs_pkg::result_t     result
);

    localparam int VARINT_MAX_BYTES = (MAX_VARINT_BITS + 6) / 7;

    // Scan phases
    localparam logic [2:0] PH_TAG   = 3'd0;
    localparam logic [2:0] PH_VALUE = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    // Verdict shares the low status codes; undecided is the "none" code
    localparam logic [1:0] VD_UNDECIDED = pbtfs_pkg::ST_NONE[1:0];
    localparam logic [1:0] VD_NOT_MEDIA = pbtfs_pkg::ST_NOT_MEDIA[1:0];
    localparam logic [1:0] VD_MEDIA     = pbtfs_pkg::ST_MEDIA[1:0];
    localparam logic [1:0] VD_MALFORMED = pbtfs_pkg::ST_MALFORMED[1:0];

    // Wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    logic [2:0]  phase_reg,   phase_next,   phase_scan;
    logic [63:0] accum_reg,   accum_next,   accum_scan;
    logic [3:0]  shift_reg,   shift_next,   shift_scan;
    logic [63:0] skip_reg,    skip_next,    skip_scan;
    logic        seen_reg,    seen_next;
    logic [1:0]  verdict_reg, verdict_next, verdict_scan;

    logic [6:0]  sh_amt;
    logic [63:0] lane;
    logic [63:0] acc_or;
    logic [3:0]  shift_inc;
    logic [31:0] field_num;
    logic [2:0]  wire_type;
    logic        type_match;

    // Place the 7 payload bits at 7 * shift
    assign sh_amt     = {shift_reg, 3'b000} - {3'b000, shift_reg};
    assign lane       = {57'd0, item.data_byte[6:0]} << sh_amt;
    assign acc_or     = accum_reg | lane;
    assign shift_inc  = shift_reg + 4'd1;
    assign field_num  = acc_or[34:3];
    assign wire_type  = acc_or[2:0];
    assign type_match = (acc_or == {32'd0, cfg.media_type_a})
                     || (acc_or == {32'd0, cfg.media_type_b});

    // Advance the scan by one byte
    always_comb begin
        phase_scan   = phase_reg;
        accum_scan   = accum_reg;
        shift_scan   = shift_reg;
        skip_scan    = skip_reg;
        verdict_scan = verdict_reg;
        if (verdict_reg == VD_UNDECIDED) begin
            if (phase_reg == PH_SKIP) begin
                // count down the payload; leave on the last byte of it
                if (skip_reg[63:1] == 63'd0) begin
                    skip_scan  = 64'd0;
                    phase_scan = PH_TAG;
                    accum_scan = 64'd0;
                    shift_scan = 4'd0;
                end else begin
                    skip_scan = skip_reg - 64'd1;
                end
            end else if (item.data_byte[7]) begin
                // varint goes on
                accum_scan = acc_or;
                shift_scan = shift_inc;
                if (shift_inc >= 4'(VARINT_MAX_BYTES)) begin
                    verdict_scan = VD_MALFORMED;
                end
            end else begin
                // varint complete: act on its value
                accum_scan = 64'd0;
                shift_scan = 4'd0;
                unique case (phase_reg)
                    PH_VALUE: begin
                        phase_scan = PH_TAG;
                    end
                    PH_LEN: begin
                        if (acc_or == 64'd0) begin
                            phase_scan = PH_TAG;
                        end else begin
                            phase_scan = PH_SKIP;
                            skip_scan  = acc_or;
                        end
                    end
                    PH_TYPE: begin
                        accum_scan   = acc_or;
                        shift_scan   = shift_reg;
                        verdict_scan = type_match ? VD_MEDIA : VD_NOT_MEDIA;
                    end
                    PH_TAG: begin
                        if (wire_type == WT_VARINT && field_num == cfg.target_field) begin
                            phase_scan = PH_TYPE;
                        end else if (wire_type == WT_VARINT) begin
                            phase_scan = PH_VALUE;
                        end else if (wire_type == WT_FIX64) begin
                            phase_scan = PH_SKIP;
                            skip_scan  = 64'd8;
                        end else if (wire_type == WT_LEN) begin
                            phase_scan = PH_LEN;
                        end else if (wire_type == WT_FIX32) begin
                            phase_scan = PH_SKIP;
                            skip_scan  = 64'd4;
                        end else begin
                            accum_scan   = acc_or;
                            shift_scan   = shift_reg;
                            verdict_scan = VD_MALFORMED;
                        end
                    end
                    default: begin
                        phase_scan = phase_reg;
                    end
                endcase
            end
        end
    end

    // Build the result of a message ending on this byte
    always_comb begin
        if (!seen_reg) begin
            result.status = pbtfs_pkg::ST_SHORT;
        end else if (verdict_scan != VD_UNDECIDED) begin
            result.status = {1'b0, verdict_scan};
        end else if (phase_scan == PH_TAG && shift_scan == 4'd0) begin
            result.status = pbtfs_pkg::ST_NONE;
        end else begin
            result.status = pbtfs_pkg::ST_MALFORMED;
        end
        result.is_media = (result.status == pbtfs_pkg::ST_MEDIA);
    end

    // Restart the scan after the last byte of a message
    always_comb begin
        if (item.last_byte) begin
            phase_next   = PH_TAG;
            accum_next   = 64'd0;
            shift_next   = 4'd0;
            skip_next    = 64'd0;
            seen_next    = 1'b0;
            verdict_next = VD_UNDECIDED;
        end else begin
            phase_next   = phase_scan;
            accum_next   = accum_scan;
            shift_next   = shift_scan;
            skip_next    = skip_scan;
            seen_next    = 1'b1;
            verdict_next = verdict_scan;
        end
    end

    // Hold scan state between bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TAG;
            accum_reg   <= 64'd0;
            shift_reg   <= 4'd0;
            skip_reg    <= 64'd0;
            seen_reg    <= 1'b0;
            verdict_reg <= VD_UNDECIDED;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            shift_reg   <= shift_next;
            skip_reg    <= skip_next;
            seen_reg    <= seen_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/protobuf_type_field_scanner.sv
// ============================================================================
// protobuf_type_field_scanner: media type check on a serialized message
// Input register, scan core and result register, plus config regs.
// ============================================================================
// Throughput: one message byte per cycle; a last byte waits while the
//   previous result is not taken.
// The result register loads as the last byte advances and drives m_tdata.
// Reset (aresetn low, synchronous): scan state restarts, both stages empty,
//   config returns to target field 10, media types 30 and 40.
`default_nettype none

module protobuf_type_field_scanner #(
    parameter int MAX_VARINT_BITS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // message byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    input  wire logic        s_tlast,    // last_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [0] is_media, [3:1] status, [7:4] zero
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    logic               in_valid_reg;
    pbtfs_pkg::item_t   in_item_reg;
    logic               out_valid_reg;
    pbtfs_pkg::result_t out_res_reg;
    pbtfs_pkg::cfg_t    cfg_reg;
    pbtfs_pkg::result_t core_res;
    logic               advance;

    // Move the held byte on unless it ends a message and the result is blocked
    assign advance  = in_valid_reg && (!in_item_reg.last_byte || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.last_byte <= s_tlast;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_field <= pbtfs_pkg::TARGET_FIELD_RST;
            cfg_reg.media_type_a <= pbtfs_pkg::MEDIA_TYPE_A_RST;
            cfg_reg.media_type_b <= pbtfs_pkg::MEDIA_TYPE_B_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pbtfs_pkg::REG_TARGET_FIELD: cfg_reg.target_field <= cfg_wdata;
                pbtfs_pkg::REG_MEDIA_TYPE_A: cfg_reg.media_type_a <= cfg_wdata;
                pbtfs_pkg::REG_MEDIA_TYPE_B: cfg_reg.media_type_b <= cfg_wdata;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    pbtfs_core #(
        .MAX_VARINT_BITS(MAX_VARINT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last_byte) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.status, out_res_reg.is_media};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_media_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_res_reg.is_media == (out_res_reg.status == pbtfs_pkg::ST_MEDIA)))
        else $error("is_media disagrees with status");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_res_reg.status <= pbtfs_pkg::ST_SHORT))
        else $error("status code out of range");

    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_item_reg.last_byte && out_valid_reg && !m_tready)
        |=> (in_valid_reg && in_item_reg.last_byte && out_valid_reg))
        else $error("last byte lost while result blocked");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.last_byte) |=> out_valid_reg)
        else $error("result not loaded after last byte");

endmodule

`default_nettype wire
